// File: hdl/latching_valve_pulse_sequencer_core_defines.svh
// Assertion macros shared by the valve pulse sequencer RTL.
`ifndef LATCHING_VALVE_PULSE_SEQUENCER_CORE_DEFINES_SVH
`define LATCHING_VALVE_PULSE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define LVPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define LVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lvps_pkg.sv
// Package with the phase codes, register indexes and reset constants of the sequencer.
`default_nettype none

package lvps_pkg;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_OPEN_START  = 3'd1,
    PH_OPEN_WAIT   = 3'd2,
    PH_OPEN_END    = 3'd3,
    PH_HOLD        = 3'd4,
    PH_CLOSE_START = 3'd5,
    PH_CLOSE_WAIT  = 3'd6,
    PH_REST        = 3'd7
  } phase_t;

  localparam logic       REG_OPEN_TIME   = 1'b0;
  localparam logic       REG_PULSE       = 1'b1;

  localparam logic [15:0] OPEN_TIME_RESET = 16'd2000;
  localparam logic [7:0]  PULSE_RESET     = 8'd20;
  localparam logic [15:0] MS_MAX          = 16'hFFFF;

endpackage

`default_nettype wire

// File: hdl/latching_valve_pulse_sequencer_core.sv
// Top level of the latching valve pulse sequencer: command handling, phase stepping, result buffer.
//
// Each input request is one millisecond tick carrying trigger_flush, close_request,
// clear_counters and a twelve-bit power_sample. The block applies the commands, advances a
// saturating millisecond counter and steps the eight-phase valve sequence, then delivers one
// result request with the coil drive level, the phase and the running counters.
// A request is accepted when in_valid is high and in_stall is low; a result is taken when
// out_valid is high and out_stall is low. The whole step is one pass of combinational logic
// from the state registers to the result register (the output register, or the skid register
// while the output is stalled), and one request can be accepted every cycle while in_stall is low.
// A two-entry result buffer (output register plus skid register) separates the two sides:
// the block still accepts a request while a finished result waits, and raises in_stall only
// when both entries are full, so a stalled receiver stops the input after one extra request.
// Configuration goes through the APB-style port: open_time_ms at byte address 0 (a zero write
// is ignored) and pulse_ms at byte address 4. Both read back. pready is always high.
// Configuration is meant to be written only while no request is in flight.
// The synchronous reset rst puts the sequence in the idle phase, clears every counter, loads
// open_time_ms with 2000 and pulse_ms with 20, and empties the result buffer.
`default_nettype none

module latching_valve_pulse_sequencer_core
  import lvps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Tick request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        trigger_flush,
  input  wire logic        close_request,
  input  wire logic        clear_counters,
  input  wire logic [11:0] power_sample,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             coil_drive,
  output logic      [2:0]  phase,
  output logic      [31:0] cycle_count,
  output logic      [31:0] total_open_ms,
  output logic      [31:0] power_sum,
  output logic      [15:0] sample_count
);

  // Result record carried through the output buffer.
  typedef struct packed {
    logic        coil_drive;
    logic [2:0]  phase;
    logic [31:0] cycle_count;
    logic [31:0] total_open_ms;
    logic [31:0] power_sum;
    logic [15:0] sample_count;
  } result_t;

  // Configuration registers.
  logic [15:0] open_time_ms;
  logic [7:0]  pulse_ms;

  // Sequencer state.
  phase_t      seq_phase, seq_phase_next;
  logic [15:0] ms_count, ms_count_next;
  logic        drive_level, drive_level_next;
  logic [31:0] cycles_done, cycles_done_next;
  logic [31:0] open_time_total, open_time_total_next;
  logic [31:0] sample_sum, sample_sum_next;
  logic [15:0] samples_taken, samples_taken_next;

  // Result buffer.
  result_t     out_data, skid_data, result_next;
  logic        skid_valid;

  logic        cfg_write;
  logic        in_fire;
  logic        out_fire;
  phase_t      cmd_phase;
  logic [15:0] ms_inc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register decode uses the word address bit; the byte offset bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_time_ms <= OPEN_TIME_RESET;
      pulse_ms     <= PULSE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_OPEN_TIME: begin
          if (pwdata[15:0] != 16'd0) begin
            open_time_ms <= pwdata[15:0];
          end
        end
        REG_PULSE: begin
          pulse_ms <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OPEN_TIME: prdata = {16'd0, open_time_ms};
      REG_PULSE:     prdata = {24'd0, pulse_ms};
      default:       prdata = 32'd0;
    endcase
  end

  // Input is held back only when both buffer entries are occupied.
  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // One tick: commands first (close wins over trigger), then the counter, then the phase step.
  always_comb begin
    if (close_request) begin
      cmd_phase = PH_CLOSE_START;
    end else if (trigger_flush) begin
      cmd_phase = PH_OPEN_START;
    end else begin
      cmd_phase = seq_phase;
    end

    ms_inc = (ms_count == MS_MAX) ? ms_count : ms_count + 16'd1;

    seq_phase_next       = cmd_phase;
    ms_count_next        = ms_inc;
    drive_level_next     = drive_level;
    cycles_done_next     = clear_counters ? 32'd0 : cycles_done;
    open_time_total_next = clear_counters ? 32'd0 : open_time_total;
    sample_sum_next      = sample_sum;
    samples_taken_next   = samples_taken;

    unique case (cmd_phase)
      PH_OPEN_START: begin
        drive_level_next = 1'b1;
        seq_phase_next   = PH_OPEN_WAIT;
        ms_count_next    = 16'd0;
      end
      PH_OPEN_WAIT, PH_CLOSE_WAIT: begin
        sample_sum_next    = sample_sum + {20'd0, power_sample};
        samples_taken_next = samples_taken + 16'd1;
        if (ms_inc >= {8'd0, pulse_ms}) begin
          seq_phase_next = (cmd_phase == PH_OPEN_WAIT) ? PH_OPEN_END : PH_REST;
        end
      end
      PH_OPEN_END: begin
        drive_level_next = 1'b0;
        seq_phase_next   = PH_HOLD;
        ms_count_next    = 16'd0;
      end
      PH_HOLD: begin
        if (ms_inc >= open_time_ms) begin
          seq_phase_next = PH_CLOSE_START;
        end
      end
      PH_CLOSE_START: begin
        drive_level_next     = 1'b1;
        seq_phase_next       = PH_CLOSE_WAIT;
        cycles_done_next     = cycles_done_next + 32'd1;
        open_time_total_next = open_time_total_next + {16'd0, open_time_ms};
        ms_count_next        = 16'd0;
      end
      PH_IDLE, PH_REST: begin
        // The rest phase behaves like idle and stays where it is.
        drive_level_next = 1'b0;
        ms_count_next    = 16'd0;
      end
      default: begin
      end
    endcase

    result_next.coil_drive    = drive_level_next;
    result_next.phase         = seq_phase_next;
    result_next.cycle_count   = cycles_done_next;
    result_next.total_open_ms = open_time_total_next;
    result_next.power_sum     = sample_sum_next;
    result_next.sample_count  = samples_taken_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase       <= PH_IDLE;
      ms_count        <= 16'd0;
      drive_level     <= 1'b0;
      cycles_done     <= 32'd0;
      open_time_total <= 32'd0;
      sample_sum      <= 32'd0;
      samples_taken   <= 16'd0;
    end else if (in_fire) begin
      seq_phase       <= seq_phase_next;
      ms_count        <= ms_count_next;
      drive_level     <= drive_level_next;
      cycles_done     <= cycles_done_next;
      open_time_total <= open_time_total_next;
      sample_sum      <= sample_sum_next;
      samples_taken   <= samples_taken_next;
    end
  end

  // Result buffer control. A new result goes to the output register when it is empty or being
  // taken, otherwise into the skid register. The skid entry moves up when the output is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || !out_stall) begin
        out_data <= result_next;
      end else begin
        skid_data <= result_next;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign coil_drive    = out_data.coil_drive;
  assign phase         = out_data.phase;
  assign cycle_count   = out_data.cycle_count;
  assign total_open_ms = out_data.total_open_ms;
  assign power_sum     = out_data.power_sum;
  assign sample_count  = out_data.sample_count;

`include "latching_valve_pulse_sequencer_core_defines.svh"

  `LVPS_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid, "skid entry without output entry")
  `LVPS_ASSERT_NEXT(a_skid_fill, in_fire && out_valid && out_stall, skid_valid, "stalled result lost")
  `LVPS_ASSERT_NOW(a_open_wait_drive, seq_phase == PH_OPEN_WAIT, drive_level, "coil off in open pulse")
  `LVPS_ASSERT_NOW(a_hold_no_drive, seq_phase == PH_HOLD, !drive_level, "coil driven while holding")
  `LVPS_ASSERT_NEXT(a_cycles_hold, !in_fire, cycles_done == $past(cycles_done), "cycle count moved without a tick")

endmodule

`default_nettype wire
